// File: rtl/mkvs_pkg.sv
// Package for the MIME key/value scanner: field widths, result codes,
// character constants, the result record and the byte class functions.
// No dependencies.
package mkvs_pkg;

	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;
	localparam int OFFS_W = 10;
	localparam int CNT_W  = 6;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [OFFS_W-1:0] offs_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAIR      = 2'd0,
		KIND_DONE      = 2'd1,
		KIND_ERR_QUOTE = 2'd2,
		KIND_ERR_BYTE  = 2'd3
	} kind_t;

	localparam cnt_t  MAX_PAIRS_RST = 6'd32;
	localparam byte_t CH_NUL   = 8'h00;
	localparam byte_t CH_EQ    = 8'h3D;
	localparam byte_t CH_QUOTE = 8'h22;
	localparam byte_t CH_SEMI  = 8'h3B;

	typedef struct packed {
		kind_t kind;
		offs_t key_first;
		offs_t key_past;
		offs_t value_first;
		offs_t value_past;
		logic  has_value;
		cnt_t  pair_count;
		byte_t bad_byte;
		logic  last_of_run;
	} res_t;

	function automatic logic is_ws(byte_t b);
		return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic logic is_token(byte_t b);
		logic special;
		special = (b == 8'h28) || (b == 8'h29) || (b == 8'h3C) || (b == 8'h3E) ||
			(b == 8'h40) || (b == 8'h2C) || (b == CH_SEMI) || (b == 8'h3A) ||
			(b == 8'h5C) || (b == CH_QUOTE) || (b == 8'h2F) || (b == 8'h5B) ||
			(b == 8'h5D) || (b == 8'h3F) || (b == CH_EQ);
		return (b >= 8'd33) && (b <= 8'd126) && !special;
	endfunction

endpackage

// File: rtl/mkvs_if.sv
// Handshake channels of the MIME key/value scanner: byte input, result
// output and configuration write. Depends on mkvs_pkg.
interface mkvs_byte_if;
	logic            valid;
	logic            ready;
	mkvs_pkg::byte_t char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink (input valid, input char_byte, output ready);
endinterface

interface mkvs_result_if;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	mkvs_pkg::offs_t   key_first;
	mkvs_pkg::offs_t   key_past;
	mkvs_pkg::offs_t   value_first;
	mkvs_pkg::offs_t   value_past;
	logic              has_value;
	mkvs_pkg::cnt_t    pair_count;
	mkvs_pkg::byte_t   bad_byte;
	logic              last_of_run;

	modport source (output valid, output kind, output key_first, output key_past,
		output value_first, output value_past, output has_value, output pair_count,
		output bad_byte, output last_of_run, input ready);
	modport sink (input valid, input kind, input key_first, input key_past,
		input value_first, input value_past, input has_value, input pair_count,
		input bad_byte, input last_of_run, output ready);
endinterface

interface mkvs_cfg_if;
	logic           valid;
	logic           ready;
	mkvs_pkg::cnt_t max_pairs;

	modport source (output valid, output max_pairs, input ready);
	modport sink (input valid, input max_pairs, output ready);
endinterface

// File: rtl/mime_key_value_scanner_unit.sv
// MIME header key[=value] scanner: one byte per item, pair/done/error results.
// Accepted bytes pass an input stage register, then results enter the queue.
// Throughput one byte per cycle while the 4-entry result queue has room for two
// results; a pair that ends the string or hits the limit adds a done result too.
// Reset: scan state restarts, max_pairs returns to 32, result queue empties.
// Depends on mkvs_pkg and the channel interfaces in mkvs_if.
module mime_key_value_scanner_unit #(
	parameter int MAX_LEN    = 1024,
	parameter int PAIR_LIMIT = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mkvs_byte_if.sink            byte_in,
	mkvs_result_if.source        result_out,
	mkvs_cfg_if.sink             cfg
);

	localparam int PW    = $clog2(MAX_LEN);
	localparam int CW    = $clog2(PAIR_LIMIT + 1);
	localparam int LW    = (CW > mkvs_pkg::CNT_W) ? CW : mkvs_pkg::CNT_W;
	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);
	localparam int FW    = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		PH_START, PH_KEY, PH_AFTER_KEY, PH_AFTER_EQ,
		PH_BARE, PH_QUOTED, PH_AFTER_QUOTE, PH_DISCARD
	} phase_t;

	typedef logic [PW-1:0] pos_t;

	phase_t            phase_q, n_phase, ph;
	pos_t              pos_q, n_pos, np;
	logic [CW-1:0]     cnt_q, n_cnt, cnt_inc;
	pos_t              kf_q, kp_q, vf_q, n_kf, n_kp, n_vf;
	mkvs_pkg::cnt_t    max_pairs_q;
	logic [LW-1:0]     limit;

	logic              valid_s1;
	mkvs_pkg::byte_t   byte_s1;
	logic              process;

	mkvs_pkg::res_t    fifo_q [DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [FW-1:0]     fill_q;
	logic              pop;

	mkvs_pkg::res_t    r0, r1;
	logic [1:0]        n_res;
	logic              go, do_pair, pair_hv, do_finish;
	pos_t              pair_vf, pair_vp;
	phase_t            pair_next;

	function automatic mkvs_pkg::offs_t to_off(pos_t p);
		return mkvs_pkg::offs_t'(p);
	endfunction

	function automatic mkvs_pkg::res_t single(mkvs_pkg::kind_t k, logic [CW-1:0] c,
		mkvs_pkg::byte_t bad);
		mkvs_pkg::res_t r;
		r = '0;
		r.kind = k;
		r.pair_count = mkvs_pkg::cnt_t'(c);
		r.bad_byte = bad;
		return r;
	endfunction

	assign limit = (LW'(max_pairs_q) < LW'(PAIR_LIMIT)) ? LW'(max_pairs_q) : LW'(PAIR_LIMIT);
	assign np = (pos_q < pos_t'(MAX_LEN - 1)) ? pos_q + pos_t'(1) : pos_q;
	assign cnt_inc = cnt_q + CW'(1);

	assign process = valid_s1 && (fill_q <= FW'(DEPTH - 2));
	assign byte_in.ready = !valid_s1 || process;
	assign cfg.ready = 1'b1;
	assign pop = result_out.valid && result_out.ready;

	always_comb begin
		n_phase = phase_q;
		n_pos = pos_q;
		n_cnt = cnt_q;
		n_kf = kf_q;
		n_kp = kp_q;
		n_vf = vf_q;
		r0 = '0;
		r1 = '0;
		n_res = 2'd0;
		ph = phase_q;
		go = 1'b0;
		do_pair = 1'b0;
		pair_hv = 1'b0;
		pair_vf = '0;
		pair_vp = '0;
		pair_next = PH_START;
		do_finish = 1'b0;

		if (phase_q == PH_DISCARD) begin
			do_finish = 1'b1;
		end else if (LW'(cnt_q) >= limit) begin
			r0 = single(mkvs_pkg::KIND_DONE, cnt_q, '0);
			n_res = 2'd1;
			do_finish = 1'b1;
		end else begin
			go = 1'b1;
			if (ph == PH_KEY) begin
				if (mkvs_pkg::is_token(byte_s1)) begin
					n_pos = np;
					go = 1'b0;
				end else begin
					n_kp = pos_q;
					ph = PH_AFTER_KEY;
				end
			end
			if (go && ph == PH_AFTER_QUOTE) begin
				if (mkvs_pkg::is_ws(byte_s1) || byte_s1 == mkvs_pkg::CH_SEMI) begin
					if (byte_s1 == mkvs_pkg::CH_SEMI) begin
						n_phase = PH_START;
					end
					n_pos = np;
					go = 1'b0;
				end else begin
					ph = PH_START;
				end
			end
			if (go && ph == PH_AFTER_EQ) begin
				if (mkvs_pkg::is_ws(byte_s1)) begin
					n_pos = np;
					go = 1'b0;
				end else if (byte_s1 == mkvs_pkg::CH_QUOTE) begin
					n_vf = np;
					n_phase = PH_QUOTED;
					n_pos = np;
					go = 1'b0;
				end else begin
					n_vf = pos_q;
					ph = PH_BARE;
				end
			end
			if (go) begin
				n_phase = ph;
				unique case (ph)
					PH_START: begin
						if (byte_s1 == mkvs_pkg::CH_NUL) begin
							r0 = single(mkvs_pkg::KIND_DONE, cnt_q, '0);
							n_res = 2'd1;
							do_finish = 1'b1;
						end else if (mkvs_pkg::is_ws(byte_s1)) begin
							n_pos = np;
						end else if (mkvs_pkg::is_token(byte_s1)) begin
							n_kf = pos_q;
							n_phase = PH_KEY;
							n_pos = np;
						end else begin
							r0 = single(mkvs_pkg::KIND_ERR_BYTE, '0, byte_s1);
							n_res = 2'd1;
							do_finish = 1'b1;
						end
					end
					PH_AFTER_KEY: begin
						if (mkvs_pkg::is_ws(byte_s1)) begin
							n_pos = np;
						end else if (byte_s1 == mkvs_pkg::CH_EQ) begin
							n_phase = PH_AFTER_EQ;
							n_pos = np;
						end else if (byte_s1 == mkvs_pkg::CH_SEMI ||
							byte_s1 == mkvs_pkg::CH_NUL) begin
							do_pair = 1'b1;
						end else begin
							r0 = single(mkvs_pkg::KIND_ERR_BYTE, '0, byte_s1);
							n_res = 2'd1;
							do_finish = 1'b1;
						end
					end
					PH_BARE: begin
						if (byte_s1 == mkvs_pkg::CH_SEMI || byte_s1 == mkvs_pkg::CH_NUL ||
							mkvs_pkg::is_ws(byte_s1)) begin
							do_pair = 1'b1;
							pair_hv = 1'b1;
							pair_vf = n_vf;
							pair_vp = pos_q;
						end else begin
							n_pos = np;
						end
					end
					PH_QUOTED: begin
						if (byte_s1 == mkvs_pkg::CH_QUOTE) begin
							do_pair = 1'b1;
							pair_hv = 1'b1;
							pair_vf = n_vf;
							pair_vp = pos_q;
							pair_next = PH_AFTER_QUOTE;
						end else if (byte_s1 == mkvs_pkg::CH_NUL) begin
							r0 = single(mkvs_pkg::KIND_ERR_QUOTE, '0, '0);
							n_res = 2'd1;
							do_finish = 1'b1;
						end else begin
							n_pos = np;
						end
					end
					default: begin
						do_finish = 1'b1;
					end
				endcase
			end
		end

		if (do_pair) begin
			r0 = '0;
			r0.kind = mkvs_pkg::KIND_PAIR;
			r0.key_first = to_off(n_kf);
			r0.key_past = to_off(n_kp);
			r0.value_first = to_off(pair_vf);
			r0.value_past = to_off(pair_vp);
			r0.has_value = pair_hv;
			n_res = 2'd1;
			n_cnt = cnt_inc;
			if (byte_s1 == mkvs_pkg::CH_NUL || LW'(cnt_inc) >= limit) begin
				r1 = single(mkvs_pkg::KIND_DONE, cnt_inc, '0);
				n_res = 2'd2;
				do_finish = 1'b1;
			end else begin
				n_phase = pair_next;
				n_pos = np;
			end
		end

		if (do_finish) begin
			if (byte_s1 == mkvs_pkg::CH_NUL) begin
				n_phase = PH_START;
				n_pos = '0;
				n_cnt = '0;
				n_kf = '0;
				n_kp = '0;
				n_vf = '0;
			end else begin
				n_phase = PH_DISCARD;
			end
		end

		if (n_res == 2'd2) begin
			r1.last_of_run = 1'b1;
		end else begin
			r0.last_of_run = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q <= PH_START;
			pos_q <= '0;
			cnt_q <= '0;
			kf_q <= '0;
			kp_q <= '0;
			vf_q <= '0;
			max_pairs_q <= mkvs_pkg::MAX_PAIRS_RST;
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (cfg.valid) begin
				max_pairs_q <= cfg.max_pairs;
			end
			if (byte_in.ready) begin
				valid_s1 <= byte_in.valid;
			end
			if (process) begin
				phase_q <= n_phase;
				pos_q <= n_pos;
				cnt_q <= n_cnt;
				kf_q <= n_kf;
				kp_q <= n_kp;
				vf_q <= n_vf;
				wr_q <= wr_q + AW'(n_res);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			fill_q <= fill_q + (process ? FW'(n_res) : FW'(0)) - (pop ? FW'(1) : FW'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.char_byte;
		end
		if (process && n_res != 2'd0) begin
			fifo_q[wr_q] <= r0;
		end
		if (process && n_res == 2'd2) begin
			fifo_q[wr_q + AW'(1)] <= r1;
		end
	end

	assign result_out.valid       = (fill_q != '0);
	assign result_out.kind        = fifo_q[rd_q].kind;
	assign result_out.key_first   = fifo_q[rd_q].key_first;
	assign result_out.key_past    = fifo_q[rd_q].key_past;
	assign result_out.value_first = fifo_q[rd_q].value_first;
	assign result_out.value_past  = fifo_q[rd_q].value_past;
	assign result_out.has_value   = fifo_q[rd_q].has_value;
	assign result_out.pair_count  = fifo_q[rd_q].pair_count;
	assign result_out.bad_byte    = fifo_q[rd_q].bad_byte;
	assign result_out.last_of_run = fifo_q[rd_q].last_of_run;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DEPTH))
		else $error("result queue overfilled");

	a_discard_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(process && phase_q == PH_DISCARD) |-> n_res == 2'd0)
		else $error("result produced while discarding");

	a_two_results: assert property (@(posedge clk) disable iff (!arst_n)
		(process && n_res == 2'd2) |-> (r0.kind == mkvs_pkg::KIND_PAIR &&
		r1.kind == mkvs_pkg::KIND_DONE))
		else $error("second result is not a done after a pair");

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= pos_t'(MAX_LEN - 1))
		else $error("position beyond saturation");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(LW'(cnt_q) <= LW'(PAIR_LIMIT)))
		else $error("pair count beyond limit");
`endif

endmodule
